### sv/lfuh_pkg.sv
package lfuh_pkg;

    // Default geometry
    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_COUNT_BITS = 16;

    // Fixed field widths
    localparam int ACT_W = 2;
    localparam int ST_W  = 3;
    localparam int CFG_W = 7;

    localparam logic [CFG_W-1:0] LIMIT_RESET = 7'd64;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_TOUCH  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_POP    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_RSVD   = 2'd3;

    // Result status codes
    localparam logic [ST_W-1:0] ST_HIT       = 3'd0;
    localparam logic [ST_W-1:0] ST_INSERTED  = 3'd1;
    localparam logic [ST_W-1:0] ST_DROPPED   = 3'd2;
    localparam logic [ST_W-1:0] ST_POPPED    = 3'd3;
    localparam logic [ST_W-1:0] ST_POP_EMPTY = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_UP_RD,
        S_UP_CMP,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_POP_RD,
        S_POP_LD,
        S_DONE
    } t_state;

endpackage

### sv/lfuh_store.sv
module lfuh_store #(
    parameter int AW         = 6,
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [KEY_BITS-1:0]   i_wkey,
    input  logic [COUNT_BITS-1:0] i_wcnt,
    input  logic [AW-1:0]         i_raddr,
    output logic [KEY_BITS-1:0]   o_rkey,
    output logic [COUNT_BITS-1:0] o_rcnt,
    output logic [KEY_BITS-1:0]   o_root_key,
    output logic [COUNT_BITS-1:0] o_root_cnt
);

    localparam int EW    = KEY_BITS + COUNT_BITS;
    localparam int DEPTH = 1 << AW;

    logic [EW-1:0]         r_mem [DEPTH];
    logic [EW-1:0]         r_rdata;
    logic [KEY_BITS-1:0]   r_root_key;
    logic [COUNT_BITS-1:0] r_root_cnt;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wkey, i_wcnt};
        end
        r_rdata <= r_mem[i_raddr];
    end

    // Shadow the root entry so the minimum is always on hand
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == '0)) begin
            r_root_key <= i_wkey;
            r_root_cnt <= i_wcnt;
        end
    end

    assign o_rkey     = r_rdata[EW-1:COUNT_BITS];
    assign o_rcnt     = r_rdata[COUNT_BITS-1:0];
    assign o_root_key = r_root_key;
    assign o_root_cnt = r_root_cnt;

endmodule

### sv/lfu_frequency_min_heap.sv
// Channel   Dir  Handshake                      Contents
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: key, count_in; tuser: action
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: count_after, min_key, min_count,
//                                               occupancy; tuser: status
// cfg       in   i_cfg_we                       i_cfg_wdata: capacity_limit
//
// One transaction at a time. A touch or insert scans the filled entries through the
// read port of the entry memory, one per cycle, then sifts: each level up reads the
// parent and then compares, each level down reads the left child, then the right child,
// then compares. A pop reads the last entry, loads it as the root, then sifts down.
// Reset (synchronous, active low) empties the heap; the entry memory needs no clearing.
// A stalled result holds the output register and a new transaction is still taken; its
// result waits for the register to free.
module lfu_frequency_min_heap #(
    parameter int CAPACITY   = lfuh_pkg::DEF_CAPACITY,
    parameter int KEY_BITS   = lfuh_pkg::DEF_KEY_BITS,
    parameter int COUNT_BITS = lfuh_pkg::DEF_COUNT_BITS,
    parameter int NW         = $clog2(CAPACITY + 1),
    parameter int IDW        = ((KEY_BITS + COUNT_BITS + 7) / 8) * 8,
    parameter int ODW        = ((2 * COUNT_BITS + KEY_BITS + NW + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [lfuh_pkg::CFG_W-1:0] i_cfg_wdata,   // capacity_limit
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [IDW-1:0]             s_axis_tdata,  // key, count_in, zero pad
    input  logic [lfuh_pkg::ACT_W-1:0] s_axis_tuser,  // action
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [ODW-1:0]             m_axis_tdata,  // count_after, min_key, min_count,
                                                      // occupancy, zero pad
    output logic [lfuh_pkg::ST_W-1:0]  m_axis_tuser   // status
);

    import lfuh_pkg::*;

    localparam int AW  = $clog2(CAPACITY);
    localparam int XW  = AW + 2;
    localparam int LW  = (NW > CFG_W) ? NW : CFG_W;
    localparam int OUW = 2 * COUNT_BITS + KEY_BITS + NW;

    t_state r_state, n_state;

    logic [CFG_W-1:0]      r_limit;
    logic [NW-1:0]         r_n, n_n;
    logic [ACT_W-1:0]      r_act, n_act;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [COUNT_BITS-1:0] r_cin, n_cin;
    logic [AW:0]           r_sidx, n_sidx;
    logic                  r_cmp_v, n_cmp_v;
    logic [AW-1:0]         r_cmp_idx, n_cmp_idx;
    logic [KEY_BITS-1:0]   r_nk, n_nk;
    logic [COUNT_BITS-1:0] r_nc, n_nc;
    logic [AW-1:0]         r_pos, n_pos;
    logic                  r_do_down, n_do_down;
    logic [KEY_BITS-1:0]   r_lk, n_lk;
    logic [COUNT_BITS-1:0] r_lc, n_lc;
    logic [ST_W-1:0]       r_status, n_status;
    logic [COUNT_BITS-1:0] r_cnt_after, n_cnt_after;

    logic                  r_ov;
    logic [ST_W-1:0]       r_o_status;
    logic [OUW-1:0]        r_o_data;

    // Memory port controls
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [KEY_BITS-1:0]   w_wkey;
    logic [COUNT_BITS-1:0] w_wcnt;
    logic [AW-1:0]         w_raddr;
    logic [KEY_BITS-1:0]   w_rkey;
    logic [COUNT_BITS-1:0] w_rcnt;
    logic [KEY_BITS-1:0]   w_root_key;
    logic [COUNT_BITS-1:0] w_root_cnt;

    // Shared decode and compares
    logic                  w_in_acc;
    logic                  w_in_pop;
    logic [KEY_BITS-1:0]   w_in_key;
    logic [COUNT_BITS-1:0] w_in_cin;
    logic                  w_issue;
    logic                  w_hit;
    logic                  w_miss;
    logic                  w_full;
    logic [COUNT_BITS-1:0] w_inc;
    logic [COUNT_BITS-1:0] w_start;
    logic [AW-1:0]         w_parent;
    logic [XW-1:0]         w_lidx;
    logic [XW-1:0]         w_ridx;
    logic                  w_has_l;
    logic                  w_has_r;
    logic                  w_pick_r;
    logic                  w_pick_l;
    logic                  w_up_move;
    logic                  w_out_free;
    logic [LW-1:0]         w_n_ext;
    logic [LW-1:0]         w_lim_ext;
    logic [KEY_BITS-1:0]   w_min_key;
    logic [COUNT_BITS-1:0] w_min_cnt;

    lfuh_store #(
        .AW         (AW),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_store (
        .i_clk      (i_clk),
        .i_we       (w_we),
        .i_waddr    (w_waddr),
        .i_wkey     (w_wkey),
        .i_wcnt     (w_wcnt),
        .i_raddr    (w_raddr),
        .o_rkey     (w_rkey),
        .o_rcnt     (w_rcnt),
        .o_root_key (w_root_key),
        .o_root_cnt (w_root_cnt)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_in_pop      = (s_axis_tuser == ACT_POP) || (s_axis_tuser == ACT_RSVD);
    assign w_in_key      = s_axis_tdata[KEY_BITS-1:0];
    assign w_in_cin      = s_axis_tdata[KEY_BITS+COUNT_BITS-1:KEY_BITS];

    // Search pipeline: issue address r_sidx, compare the entry read last cycle
    assign w_issue = (XW'(r_sidx) < XW'(r_n));
    assign w_hit   = r_cmp_v && (w_rkey == r_key);
    assign w_miss  = !r_cmp_v && !w_issue;

    // Limit clamp: zero acts as one, CAPACITY caps the rest
    assign w_n_ext   = LW'(r_n);
    assign w_lim_ext = (r_limit == '0) ? LW'(1) : LW'(r_limit);
    assign w_full    = (w_n_ext >= w_lim_ext) || (XW'(r_n) >= XW'(CAPACITY));

    assign w_inc   = (w_rcnt == '1) ? w_rcnt : (w_rcnt + 1'b1);
    assign w_start = (r_act == ACT_INSERT) ? ((r_cin == '0) ? COUNT_BITS'(1) : r_cin)
                                           : COUNT_BITS'(1);

    // Heap index arithmetic
    assign w_parent = AW'((r_pos - 1'b1) >> 1);
    assign w_lidx   = XW'({r_pos, 1'b1});
    assign w_ridx   = XW'({r_pos, 1'b0}) + XW'(2);
    assign w_has_l  = (w_lidx < XW'(r_n));
    assign w_has_r  = (w_ridx < XW'(r_n));
    assign w_pick_r = w_has_r && (w_rcnt < r_lc) && (w_rcnt < r_nc);
    assign w_pick_l = !w_pick_r && (r_lc < r_nc);
    assign w_up_move = (r_nc < w_rcnt);

    assign w_out_free = !r_ov || m_axis_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (!w_in_pop) begin
                        n_state = S_SRCH;
                    end else if (r_n > NW'(1)) begin
                        n_state = S_POP_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SRCH: begin
                if (w_hit) begin
                    n_state = S_UP_RD;
                end else if (w_miss) begin
                    n_state = w_full ? S_DONE : S_UP_RD;
                end
            end
            S_UP_RD: begin
                if (r_pos != '0) begin
                    n_state = S_UP_CMP;
                end else begin
                    n_state = r_do_down ? S_DN_L : S_DONE;
                end
            end
            S_UP_CMP: begin
                if (w_up_move) begin
                    n_state = S_UP_RD;
                end else begin
                    n_state = r_do_down ? S_DN_L : S_DONE;
                end
            end
            S_DN_L:   n_state = w_has_l ? S_DN_R : S_DONE;
            S_DN_R:   n_state = S_DN_CMP;
            S_DN_CMP: n_state = (w_pick_r || w_pick_l) ? S_DN_L : S_DONE;
            S_POP_RD: n_state = S_POP_LD;
            S_POP_LD: n_state = S_DN_L;
            S_DONE:   n_state = w_out_free ? S_IDLE : S_DONE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_n         = r_n;
        n_act       = r_act;
        n_key       = r_key;
        n_cin       = r_cin;
        n_sidx      = r_sidx;
        n_cmp_v     = r_cmp_v;
        n_cmp_idx   = r_cmp_idx;
        n_nk        = r_nk;
        n_nc        = r_nc;
        n_pos       = r_pos;
        n_do_down   = r_do_down;
        n_lk        = r_lk;
        n_lc        = r_lc;
        n_status    = r_status;
        n_cnt_after = r_cnt_after;
        w_we        = 1'b0;
        w_waddr     = r_pos;
        w_wkey      = r_nk;
        w_wcnt      = r_nc;
        w_raddr     = r_sidx[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_act     = s_axis_tuser;
                    n_key     = w_in_key;
                    n_cin     = w_in_cin;
                    n_sidx    = '0;
                    n_cmp_v   = 1'b0;
                    n_pos     = '0;
                    n_do_down = 1'b1;
                    if (w_in_pop) begin
                        if (r_n == '0) begin
                            n_status    = ST_POP_EMPTY;
                            n_cnt_after = '0;
                        end else begin
                            n_status    = ST_POPPED;
                            n_cnt_after = w_root_cnt;
                            n_n         = r_n - 1'b1;
                        end
                    end
                end
            end
            S_SRCH: begin
                w_raddr = r_sidx[AW-1:0];
                if (w_hit) begin
                    n_nk        = r_key;
                    n_nc        = w_inc;
                    n_pos       = r_cmp_idx;
                    n_status    = ST_HIT;
                    n_cnt_after = w_inc;
                    n_do_down   = 1'b1;
                end else if (w_miss) begin
                    if (w_full) begin
                        n_status    = ST_DROPPED;
                        n_cnt_after = '0;
                    end else begin
                        n_nk        = r_key;
                        n_nc        = w_start;
                        n_pos       = AW'(r_n);
                        n_n         = r_n + 1'b1;
                        n_status    = ST_INSERTED;
                        n_cnt_after = w_start;
                        n_do_down   = 1'b0;
                    end
                end else begin
                    n_cmp_v   = w_issue;
                    n_cmp_idx = r_sidx[AW-1:0];
                    if (w_issue) begin
                        n_sidx = r_sidx + 1'b1;
                    end
                end
            end
            S_UP_RD: begin
                w_raddr = w_parent;
                // at the root: park the node unless a sift-down follows
                if (r_pos == '0 && !r_do_down) begin
                    w_we = 1'b1;
                end
            end
            S_UP_CMP: begin
                w_raddr = w_parent;
                if (w_up_move) begin
                    // pull the parent down into the hole
                    w_we   = 1'b1;
                    w_wkey = w_rkey;
                    w_wcnt = w_rcnt;
                    n_pos  = w_parent;
                end else if (!r_do_down) begin
                    w_we = 1'b1;
                end
            end
            S_DN_L: begin
                w_raddr = w_lidx[AW-1:0];
                if (!w_has_l) begin
                    w_we = 1'b1;
                end
            end
            S_DN_R: begin
                w_raddr = w_ridx[AW-1:0];
                n_lk    = w_rkey;
                n_lc    = w_rcnt;
            end
            S_DN_CMP: begin
                w_raddr = w_ridx[AW-1:0];
                w_we    = 1'b1;
                if (w_pick_r) begin
                    w_wkey = w_rkey;
                    w_wcnt = w_rcnt;
                    n_pos  = w_ridx[AW-1:0];
                end else if (w_pick_l) begin
                    w_wkey = r_lk;
                    w_wcnt = r_lc;
                    n_pos  = w_lidx[AW-1:0];
                end
            end
            S_POP_RD: begin
                // fetch the last entry, it moves to the root
                w_raddr = AW'(r_n);
            end
            S_POP_LD: begin
                n_nk  = w_rkey;
                n_nc  = w_rcnt;
                n_pos = '0;
            end
            S_DONE: begin
                w_raddr = r_pos;
            end
            default: begin
                w_raddr = r_pos;
            end
        endcase
    end

    assign w_min_key = (r_n != '0) ? w_root_key : '0;
    assign w_min_cnt = (r_n != '0) ? w_root_cnt : '0;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= '0;
            r_limit <= LIMIT_RESET;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            // hold the result until taken, load when the step finishes
            if (r_state == S_DONE && w_out_free) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_act       <= n_act;
        r_key       <= n_key;
        r_cin       <= n_cin;
        r_sidx      <= n_sidx;
        r_cmp_v     <= n_cmp_v;
        r_cmp_idx   <= n_cmp_idx;
        r_nk        <= n_nk;
        r_nc        <= n_nc;
        r_pos       <= n_pos;
        r_do_down   <= n_do_down;
        r_lk        <= n_lk;
        r_lc        <= n_lc;
        r_status    <= n_status;
        r_cnt_after <= n_cnt_after;
        if (r_state == S_DONE && w_out_free) begin
            r_o_status <= r_status;
            r_o_data   <= {r_n, w_min_cnt, w_min_key, r_cnt_after};
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tdata  = ODW'(r_o_data);

endmodule

### test/lfu_frequency_min_heap_tb.sv
module lfu_frequency_min_heap_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lfuh_pkg::*;

    localparam int CAP   = DEF_CAPACITY;
    localparam int KB    = DEF_KEY_BITS;
    localparam int CB    = DEF_COUNT_BITS;
    localparam int NW    = $clog2(CAP + 1);
    localparam int IDW   = ((KB + CB + 7) / 8) * 8;
    localparam int ODW   = ((2 * CB + KB + NW + 7) / 8) * 8;
    localparam int DRAIN = 200;

    // Laid out to match {tuser, tdata}: status on top, then occupancy, count_after lowest
    typedef struct packed {
        logic [ST_W-1:0] status;
        logic [NW-1:0]   occupancy;
        logic [CB-1:0]   min_count;
        logic [KB-1:0]   min_key;
        logic [CB-1:0]   count_after;
    } t_lfu_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_W-1:0]  i_cfg_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IDW-1:0]    s_axis_tdata;   // key, count_in, zero pad
    logic [ACT_W-1:0]  s_axis_tuser;   // action
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [ODW-1:0]    m_axis_tdata;   // count_after, min_key, min_count, occupancy, pad
    logic [ST_W-1:0]   m_axis_tuser;   // status

    lfu_frequency_min_heap i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Shadow heap of the block
    logic [KB-1:0]    shadow_keys [CAP];
    logic [CB-1:0]    shadow_counts [CAP];
    int unsigned      shadow_fill;
    logic [CFG_W-1:0] shadow_limit;

    t_lfu_result expected_results[$];
    int  mismatch_count;
    int  sent_count;
    int  checked_count;
    int  hit_seen, insert_seen, drop_seen, pop_seen, pop_empty_seen;
    bit  rx_hold;          // long receiver hold-off in progress
    bit  rx_quiet;         // receiver always ready

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void swap_entries(int a, int b);
        logic [KB-1:0] k;
        logic [CB-1:0] c;
        k = shadow_keys[a];
        c = shadow_counts[a];
        shadow_keys[a] = shadow_keys[b];
        shadow_counts[a] = shadow_counts[b];
        shadow_keys[b] = k;
        shadow_counts[b] = c;
    endfunction

    function automatic int bubble_up(int pos);
        int parent;
        while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (shadow_counts[pos] < shadow_counts[parent]) begin
                swap_entries(pos, parent);
                pos = parent;
            end else begin
                break;
            end
        end
        return pos;
    endfunction

    function automatic void bubble_down(int pos);
        int l, r, best;
        while (pos < shadow_fill) begin
            l = 2 * pos + 1;
            r = 2 * pos + 2;
            best = pos;
            if (l < shadow_fill && shadow_counts[l] < shadow_counts[best])
                best = l;
            if (r < shadow_fill && shadow_counts[r] < shadow_counts[best]
                && shadow_counts[r] < shadow_counts[l])
                best = r;
            if (best == pos)
                break;
            swap_entries(pos, best);
            pos = best;
        end
    endfunction

    // Apply one access to the shadow heap and return the reported result
    function automatic t_lfu_result lfu_access(logic [ACT_W-1:0] action,
                                               logic [KB-1:0] key, logic [CB-1:0] cnt_in);
        t_lfu_result res;
        int at, lim;
        bit found;
        res = '0;
        if (action == ACT_POP || action == ACT_RSVD) begin
            if (shadow_fill == 0) begin
                res.status = ST_POP_EMPTY;
            end else begin
                res.status = ST_POPPED;
                res.count_after = shadow_counts[0];
                shadow_fill--;
                if (shadow_fill > 0) begin
                    shadow_keys[0] = shadow_keys[shadow_fill];
                    shadow_counts[0] = shadow_counts[shadow_fill];
                    bubble_down(0);
                end
            end
        end else begin
            found = 1'b0;
            at = 0;
            for (int i = 0; i < shadow_fill; i++) begin
                if (shadow_keys[i] == key) begin
                    found = 1'b1;
                    at = i;
                    break;
                end
            end
            lim = shadow_limit;
            if (lim < 1) lim = 1;
            if (lim > CAP) lim = CAP;
            if (found) begin
                res.status = ST_HIT;
                if (shadow_counts[at] != '1)
                    shadow_counts[at] = shadow_counts[at] + 1'b1;
                res.count_after = shadow_counts[at];
                at = bubble_up(at);
                bubble_down(at);
            end else if (shadow_fill >= lim) begin
                res.status = ST_DROPPED;
            end else begin
                res.status = ST_INSERTED;
                res.count_after = (action == ACT_INSERT && cnt_in != '0) ? cnt_in : CB'(1);
                shadow_keys[shadow_fill] = key;
                shadow_counts[shadow_fill] = res.count_after;
                shadow_fill++;
                void'(bubble_up(shadow_fill - 1));
            end
        end
        if (shadow_fill > 0) begin
            res.min_key = shadow_keys[0];
            res.min_count = shadow_counts[0];
        end
        res.occupancy = NW'(shadow_fill);
        return res;
    endfunction

    // Offer one transaction after a random gap; predict on acceptance
    task automatic send_access(logic [ACT_W-1:0] action, logic [KB-1:0] key,
                               logic [CB-1:0] cnt_in, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                      : $urandom_range(0, 2));
        // drop valid only for a real gap, otherwise keep offering back to back
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= action;
        s_axis_tdata  <= IDW'({cnt_in, key});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_results.push_back(lfu_access(action, key, cnt_in));
        sent_count++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [CFG_W-1:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_limit = value;
    endtask

    // Pick a key from a small pool, often one already resident
    function automatic logic [KB-1:0] pick_key();
        if (shadow_fill > 0 && $urandom_range(0, 2) != 0)
            return shadow_keys[$urandom_range(0, shadow_fill - 1)];
        return KB'($urandom_range(0, 40));
    endfunction

    // Receiver: random stalls, skipped during quiet phases and forced during hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n || rx_quiet)
            m_axis_tready <= 1'b1;
        else if (rx_hold)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_lfu_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata[2*CB+KB+NW-1:0]};
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result %h", got);
            end else begin
                want = expected_results.pop_front();
                checked_count++;
                case (want.status)
                    ST_HIT:       hit_seen++;
                    ST_INSERTED:  insert_seen++;
                    ST_DROPPED:   drop_seen++;
                    ST_POPPED:    pop_seen++;
                    default:      pop_empty_seen++;
                endcase
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"ERROR: result %0d exp st=%0d cnt=%0d min=%h/%0d occ=%0d",
                                  " got st=%0d cnt=%0d min=%h/%0d occ=%0d"},
                                 checked_count, want.status, want.count_after,
                                 want.min_key, want.min_count, want.occupancy,
                                 got.status, got.count_after, got.min_key,
                                 got.min_count, got.occupancy);
                end
            end
        end
    end

    task automatic test_directed();
        send_access(ACT_POP, '0, '0);
        send_access(ACT_RSVD, '1, '1);
        send_access(ACT_TOUCH, '1, '0);
        send_access(ACT_TOUCH, '1, '0);
        send_access(ACT_INSERT, '0, '1);
        send_access(ACT_INSERT, '0, CB'(5));
        send_access(ACT_INSERT, 32'hA5A5_5A5A, '0);
        send_access(ACT_INSERT, 32'h0000_0007, CB'(3));
        send_access(ACT_INSERT, 32'h0000_0008, CB'(3));
        send_access(ACT_INSERT, 32'h0000_0009, CB'(2));
        // saturate the largest count
        send_access(ACT_TOUCH, '0, '0);
        send_access(ACT_INSERT, 32'h0000_0007, CB'(100));
        send_access(ACT_POP, '0, '0);
        send_access(ACT_RSVD, '0, '0);
        send_access(ACT_POP, '0, '0);
        send_access(ACT_POP, '0, '0);
        send_access(ACT_POP, '0, '0);
        send_access(ACT_POP, '0, '0);
        send_access(ACT_POP, '0, '0);
    endtask

    task automatic test_limits();
        // limit of zero acts as one
        write_limit('0);
        send_access(ACT_TOUCH, 32'h11, '0);
        send_access(ACT_TOUCH, 32'h12, '0);
        send_access(ACT_TOUCH, 32'h11, '0);
        // above capacity acts as capacity
        write_limit(7'd127);
        for (int i = 0; i < CAP + 2; i++)
            send_access(ACT_INSERT, KB'($urandom), CB'($urandom_range(1, 20)));
        // lower below occupancy: resident keys stay, new ones drop
        write_limit(7'd3);
        send_access(ACT_TOUCH, shadow_keys[5], '0);
        send_access(ACT_TOUCH, 32'hDEAD_BEEF, '0);
        repeat (CAP) send_access(ACT_POP, '0, '0, 1);
    endtask

    task automatic test_backpressure();
        // hold the receiver off long enough that the block stalls its input
        write_limit(LIMIT_RESET);
        fork
            begin
                rx_hold = 1'b1;
                repeat (800) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            begin
                for (int i = 0; i < 6; i++)
                    send_access(ACT_TOUCH, pick_key(), '0, 1);
                s_axis_tvalid <= 1'b0;
            end
        join
        wait_drained();
    endtask

    task automatic test_random(int items, logic [CFG_W-1:0] limit);
        int sel;
        write_limit(limit);
        for (int i = 0; i < items; i++) begin
            sel = $urandom_range(0, 9);
            if (sel < 4)
                send_access(ACT_TOUCH, pick_key(), CB'($urandom));
            else if (sel < 7)
                send_access(ACT_INSERT, pick_key(),
                            ($urandom_range(0, 4) == 0) ? CB'($urandom)
                                                        : CB'($urandom_range(0, 12)));
            else
                send_access(($urandom_range(0, 3) == 0) ? ACT_RSVD : ACT_POP,
                            KB'($urandom), CB'($urandom));
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_TOUCH;
        rx_hold        = 1'b0;
        rx_quiet       = 1'b0;
        mismatch_count = 0;
        sent_count     = 0;
        checked_count  = 0;
        shadow_fill    = 0;
        shadow_limit   = LIMIT_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_limits();
        test_backpressure();
        test_random(150, LIMIT_RESET);
        test_random(100, 7'd5);
        rx_quiet = 1'b1;
        test_random(80, 7'd1);
        rx_quiet = 1'b0;
        test_random(120, 7'd20);
        wait_drained();

        $display("Ran %0d transactions, checked %0d results: %0d hits, %0d inserts,",
                 sent_count, checked_count, hit_seen, insert_seen);
        $display("%0d drops, %0d pops, %0d empty pops over limits 0, 1, 3, 5, 20, 64, 127",
                 drop_seen, pop_seen, pop_empty_seen);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d results missing",
                     mismatch_count, expected_results.size());
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("ERROR: timeout");
        $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
sv/lfuh_pkg.sv
sv/lfuh_store.sv
sv/lfu_frequency_min_heap.sv
test/lfu_frequency_min_heap_tb.sv
